/* rtl/pmmd_pkg.sv */
// Package for the particle mesh mass deposit block: sizes, codes and types.
// No dependencies.
package pmmd_pkg;
   localparam int GRID_BITS  = 5;
   localparam int GRID_SIZE  = 1 << GRID_BITS;
   localparam int CELL_BITS  = 3 * GRID_BITS;
   localparam int CELL_COUNT = 1 << CELL_BITS;
   localparam int COORD_BITS = 24;
   localparam int WFRAC_BITS = 16;
   localparam int W_BITS     = WFRAC_BITS + 1;
   localparam int POS_BITS   = 24;
   localparam int IDX_BITS   = 15;
   localparam int VAL_BITS   = 32;

   localparam logic [1:0] SCHEME_NGP = 2'd0;
   localparam logic [1:0] SCHEME_CIC = 2'd1;
   localparam logic [1:0] SCHEME_TSC = 2'd2;
   localparam logic [0:0] KIND_DEPOSIT = 1'b0;
   localparam logic [0:0] KIND_READ    = 1'b1;
   localparam logic [1:0] REG_SCHEME = 2'd0;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_AXIS, ST_WMUL1, ST_WMUL2, ST_RD, ST_WAIT, ST_WR,
      ST_RDCELL, ST_RDWAIT, ST_OUT
   } state_type;

   typedef struct packed {
      logic [GRID_BITS-1:0] idx;
      logic [W_BITS-1:0]    w;
   } tap_type;
endpackage

/* rtl/pmmd_if.sv */
// Valid/ready channel interfaces for the mass deposit block.
// Depends on pmmd_pkg.
interface pmmd_req_if import pmmd_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [0:0]          kind;
   logic [POS_BITS-1:0] pos_x;
   logic [POS_BITS-1:0] pos_y;
   logic [POS_BITS-1:0] pos_z;
   logic [IDX_BITS-1:0] cell_index;
   modport source (output valid, kind, pos_x, pos_y, pos_z, cell_index, input ready);
   modport sink (input valid, kind, pos_x, pos_y, pos_z, cell_index, output ready);
endinterface

interface pmmd_rsp_if import pmmd_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [VAL_BITS-1:0] cell_value;
   logic                saturated;
   modport source (output valid, cell_value, saturated, input ready);
   modport sink (input valid, cell_value, saturated, output ready);
endinterface

/* rtl/pmmd_ram.sv */
// Generic single-port RAM with registered read data.
// No dependencies.
module pmmd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

/* rtl/particle_mesh_mass_deposit.sv */
// Top level of the particle mesh mass deposit block.
// Depends on pmmd_pkg, pmmd_if and pmmd_ram.
//
// Requests arrive on req (valid/ready). A deposit request spreads one unit
// mass over 1, 8 or 27 cells of a periodic 32^3 grid, as the assign_scheme
// register selects (0 NGP, 1 CIC, 2 TSC, 3 no effect), and returns nothing.
// A read request returns one cell and the sticky saturation flag on rsp.
// The grid sits in one single-port RAM, and one shared 17x17 multiplier
// forms the TSC axis weights and all cell weights. Every cell update takes
// two weight products, then a read, a wait for the registered read data
// and a saturating write. Each TSC axis takes three products; NGP and CIC
// form their axis weights without the multiplier. A read passes through
// RDCELL, RDWAIT and OUT; the result is held stable while the receiver
// holds rsp_ready low, and no request is taken until it is delivered.
// After reset a clearing pass writes zero to all 32768 cells, one a cycle,
// and req_ready stays low until it ends. The csr APB port is always ready
// and is taken also during the clearing pass.
module particle_mesh_mass_deposit
   import pmmd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   pmmd_req_if.sink      req,
   pmmd_rsp_if.source    rsp,
   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [1:0]    csr_paddr,
   input  logic [31:0]   csr_pwdata,
   output logic [31:0]   csr_prdata,
   output logic          csr_pready
);
   localparam logic [W_BITS-1:0] WONE  = W_BITS'(1) << WFRAC_BITS;
   localparam logic [W_BITS-1:0] WHALF = W_BITS'(1) << (WFRAC_BITS - 1);
   localparam logic [W_BITS-1:0] W3Q   = W_BITS'(3) << (WFRAC_BITS - 2);

   state_type state_ff, state_in;
   logic [1:0] scheme_ff;
   logic       sat_ff, sat_in;
   logic [CELL_BITS-1:0] clr_ff, clr_in;
   logic [POS_BITS-1:0] pos_ff [3];
   logic [POS_BITS-1:0] pos_in [3];
   tap_type tap_ff [3][3];
   tap_type tap_in [3][3];
   logic [1:0] axis_ff, axis_in;   // which axis is in work
   logic [1:0] step_ff, step_in;   // which product within the axis or cell
   logic [1:0] ca_ff, cb_ff, cc_ff, ca_in, cb_in, cc_in;
   logic [W_BITS-1:0] cw_ff, cw_in;
   logic [CELL_BITS-1:0] addr_ff, addr_in;
   logic [VAL_BITS-1:0] val_ff, val_in;

   // Shared multiplier.
   logic [W_BITS-1:0]     mul_a, mul_b;
   logic [2*W_BITS-1:0]   mul_p;
   logic [W_BITS-1:0]     mul_q;
   assign mul_p = mul_a * mul_b;
   assign mul_q = W_BITS'(mul_p >> WFRAC_BITS);

   logic ram_we;
   logic [CELL_BITS-1:0] ram_addr;
   logic [VAL_BITS-1:0] ram_wd, ram_rd;

   pmmd_ram #(.WIDTH(VAL_BITS), .DEPTH(CELL_COUNT)) u_ram (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr), .wr_data(ram_wd), .rd_data(ram_rd)
   );

   assign csr_pready = 1'b1;
   assign csr_prdata = {30'd0, scheme_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         scheme_ff <= SCHEME_CIC;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == 2'(REG_SCHEME)) begin
         scheme_ff <= csr_pwdata[1:0];
      end
   end

   // Number of taps per axis for the current scheme, minus one.
   logic [1:0] last_tap;
   always_comb begin
      case (scheme_ff)
         SCHEME_NGP: last_tap = 2'd0;
         SCHEME_CIC: last_tap = 2'd1;
         default:    last_tap = 2'd2;
      endcase
   end

   // Axis position scaled by the grid size.
   logic [POS_BITS-1:0]   cur_pos;
   logic [COORD_BITS-1:0] frac_s, frac_r;
   logic [GRID_BITS-1:0]  i_s, i_r;
   logic [W_BITS-1:0]     d_w, e_w, m_w;
   assign cur_pos = pos_ff[axis_ff];
   assign {i_s, frac_s} = {cur_pos[COORD_BITS-GRID_BITS-1:0], {GRID_BITS{1'b0}}} == '0 ?
          {cur_pos[COORD_BITS-1 -: GRID_BITS], COORD_BITS'(0)} :
          {cur_pos[COORD_BITS-1 -: GRID_BITS], cur_pos[COORD_BITS-GRID_BITS-1:0],
           {GRID_BITS{1'b0}}};
   assign {i_r, frac_r} = {i_s, frac_s} + {{GRID_BITS{1'b0}}, 1'b1, {(COORD_BITS-1){1'b0}}};
   assign d_w = W_BITS'(frac_s >> (COORD_BITS - WFRAC_BITS));
   assign e_w = W_BITS'(frac_r >> (COORD_BITS - WFRAC_BITS));
   assign m_w = (e_w >= WHALF) ? e_w - WHALF : WHALF - e_w;

   always_comb begin
      state_in = state_ff;
      sat_in = sat_ff;
      clr_in = clr_ff;
      pos_in = pos_ff;
      tap_in = tap_ff;
      axis_in = axis_ff;
      step_in = step_ff;
      ca_in = ca_ff; cb_in = cb_ff; cc_in = cc_ff;
      cw_in = cw_ff;
      addr_in = addr_ff;
      val_in = val_ff;
      mul_a = '0; mul_b = '0;
      ram_we = 1'b0; ram_addr = addr_ff; ram_wd = '0;
      req.ready = 1'b0;
      rsp.valid = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1; ram_addr = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == CELL_BITS'(CELL_COUNT - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               pos_in[0] = req.pos_x; pos_in[1] = req.pos_y; pos_in[2] = req.pos_z;
               addr_in = req.cell_index;
               axis_in = '0; step_in = '0;
               if (req.kind == KIND_READ) state_in = ST_RDCELL;
               else if (scheme_ff != 2'd3) state_in = ST_AXIS;
            end
         end
         ST_AXIS: begin
            // Up to three products of the shared multiplier per axis.
            case (scheme_ff)
               SCHEME_NGP: begin
                  tap_in[axis_ff][0] = '{idx: i_s, w: WONE};
                  step_in = 2'd2;
               end
               SCHEME_CIC: begin
                  tap_in[axis_ff][0] = '{idx: i_s, w: WONE - d_w};
                  tap_in[axis_ff][1] = '{idx: i_s + 1'b1, w: d_w};
                  step_in = 2'd2;
               end
               default: begin
                  case (step_ff)
                     2'd0: begin
                        mul_a = WONE - e_w; mul_b = WONE - e_w;
                        tap_in[axis_ff][0] = '{idx: i_r - 1'b1, w: mul_q >> 1};
                     end
                     2'd1: begin
                        mul_a = m_w; mul_b = m_w;
                        tap_in[axis_ff][1] = '{idx: i_r, w: W3Q - mul_q};
                     end
                     default: begin
                        mul_a = e_w; mul_b = e_w;
                        tap_in[axis_ff][2] = '{idx: i_r + 1'b1, w: mul_q >> 1};
                     end
                  endcase
                  step_in = step_ff + 1'b1;
               end
            endcase
            if (step_ff == 2'd2 || scheme_ff != SCHEME_TSC) begin
               step_in = '0;
               axis_in = axis_ff + 1'b1;
               if (axis_ff == 2'd2) begin
                  state_in = ST_WMUL1;
                  ca_in = '0; cb_in = '0; cc_in = '0;
               end
            end
         end
         ST_WMUL1: begin
            mul_a = tap_ff[0][ca_ff].w; mul_b = tap_ff[1][cb_ff].w;
            cw_in = mul_q;
            state_in = ST_WMUL2;
         end
         ST_WMUL2: begin
            mul_a = cw_ff; mul_b = tap_ff[2][cc_ff].w;
            cw_in = mul_q;
            addr_in = {tap_ff[2][cc_ff].idx, tap_ff[1][cb_ff].idx, tap_ff[0][ca_ff].idx};
            state_in = ST_RD;
         end
         ST_RD: state_in = ST_WAIT;
         ST_WAIT: state_in = ST_WR;
         ST_WR: begin
            logic [VAL_BITS:0] sum;
            sum = {1'b0, ram_rd} + (VAL_BITS+1)'(cw_ff);
            ram_we = 1'b1;
            if (sum[VAL_BITS]) begin
               ram_wd = '1; sat_in = 1'b1;
            end else begin
               ram_wd = sum[VAL_BITS-1:0];
            end
            state_in = ST_WMUL1;
            if (cc_ff != last_tap) cc_in = cc_ff + 1'b1;
            else begin
               cc_in = '0;
               if (cb_ff != last_tap) cb_in = cb_ff + 1'b1;
               else begin
                  cb_in = '0;
                  if (ca_ff != last_tap) ca_in = ca_ff + 1'b1;
                  else state_in = ST_IDLE;
               end
            end
         end
         ST_RDCELL: state_in = ST_RDWAIT;
         ST_RDWAIT: begin
            val_in = ram_rd;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            rsp.valid = 1'b1;
            if (rsp.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp.cell_value = val_ff;
   assign rsp.saturated  = sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         sat_ff <= 1'b0;
         clr_ff <= '0;
         axis_ff <= '0;
         step_ff <= '0;
      end else begin
         state_ff <= state_in;
         sat_ff <= sat_in;
         clr_ff <= clr_in;
         axis_ff <= axis_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      tap_ff <= tap_in;
      ca_ff <= ca_in; cb_ff <= cb_in; cc_ff <= cc_in;
      cw_ff <= cw_in;
      addr_ff <= addr_in;
      val_ff <= val_in;
   end
endmodule

/* bench/testbench.sv */
// Self-checking bench for particle_mesh_mass_deposit: directed table, random deposits and
// reads under several assignment schemes, and a pile of deposits on one cell. Depends on
// pmmd_pkg, pmmd_if and the block itself.
module testbench;
   import pmmd_pkg::*;

   localparam logic [1:0] SCHEME_UNUSED = 2'd3;
   localparam longint unsigned UNIT_MASS = 64'd1 << WFRAC_BITS;
   localparam longint unsigned COORD_MASK = (64'd1 << COORD_BITS) - 1;

   typedef struct {
      logic [VAL_BITS-1:0] value;
      logic                sat;
   } cell_read_t;

   typedef struct {
      logic [1:0]          scheme;
      logic [0:0]          kind;
      logic [POS_BITS-1:0] x, y, z;
      logic [IDX_BITS-1:0] index;
      bit                  typed;
      logic [VAL_BITS-1:0] value;
      logic                sat;
   } stim_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   pmmd_req_if req_bus ();
   pmmd_rsp_if rsp_bus ();

   particle_mesh_mass_deposit u_top (
      .clock(clock), .reset(reset), .req(req_bus), .rsp(rsp_bus),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #1 clock = ~clock;

   // Mirror of the grid, the sticky flag and the scheme register.
   logic [VAL_BITS-1:0] grid_mirror [CELL_COUNT];
   logic                sat_mirror;
   logic [1:0]          scheme_mirror;
   cell_read_t          pending_reads [$];
   int                  failures = 0;
   int                  sender_idle = 0;
   int                  receiver_idle = 0;
   int                  long_hold = 0;

   initial begin
      req_bus.valid = 1'b0;
      req_bus.kind = KIND_DEPOSIT;
      req_bus.pos_x = '0;
      req_bus.pos_y = '0;
      req_bus.pos_z = '0;
      req_bus.cell_index = '0;
      rsp_bus.ready = 1'b0;
   end

   task automatic axis_weights(input logic [POS_BITS-1:0] pos, input logic [1:0] scheme,
                               output int taps, output int idx [3],
                               output longint unsigned w [3]);
      longint unsigned s, r, d, e, m, q;
      int i;
      s = (longint'(pos) & COORD_MASK) * GRID_SIZE;
      if (scheme == SCHEME_NGP) begin
         taps = 1;
         idx[0] = int'((s >> COORD_BITS) % GRID_SIZE);
         w[0] = UNIT_MASS;
      end else if (scheme == SCHEME_CIC) begin
         taps = 2;
         i = int'((s >> COORD_BITS) % GRID_SIZE);
         d = (s & COORD_MASK) >> (COORD_BITS - WFRAC_BITS);
         idx[0] = i;
         idx[1] = (i + 1) % GRID_SIZE;
         w[0] = UNIT_MASS - d;
         w[1] = d;
      end else begin
         taps = 3;
         r = s + (64'd1 << (COORD_BITS - 1));
         i = int'((r >> COORD_BITS) % GRID_SIZE);
         e = (r & COORD_MASK) >> (COORD_BITS - WFRAC_BITS);
         m = (e >= UNIT_MASS / 2) ? e - UNIT_MASS / 2 : UNIT_MASS / 2 - e;
         q = UNIT_MASS - e;
         idx[0] = (i + GRID_SIZE - 1) % GRID_SIZE;
         idx[1] = i;
         idx[2] = (i + 1) % GRID_SIZE;
         w[0] = ((q * q) >> WFRAC_BITS) >> 1;
         w[1] = (UNIT_MASS * 3 / 4) - ((m * m) >> WFRAC_BITS);
         w[2] = ((e * e) >> WFRAC_BITS) >> 1;
      end
   endtask

   task automatic deposit_particle(input logic [POS_BITS-1:0] px, py, pz);
      int nx, ny, nz, addr;
      int ix [3], iy [3], iz [3];
      longint unsigned wx [3], wy [3], wz [3];
      longint unsigned wt, sum;
      if (scheme_mirror == SCHEME_UNUSED) return;
      axis_weights(px, scheme_mirror, nx, ix, wx);
      axis_weights(py, scheme_mirror, ny, iy, wy);
      axis_weights(pz, scheme_mirror, nz, iz, wz);
      for (int a = 0; a < nx; a++)
         for (int b = 0; b < ny; b++)
            for (int c = 0; c < nz; c++) begin
               wt = (((wx[a] * wy[b]) >> WFRAC_BITS) * wz[c]) >> WFRAC_BITS;
               addr = ix[a] + GRID_SIZE * (iy[b] + GRID_SIZE * iz[c]);
               sum = longint'(grid_mirror[addr]) + wt;
               if (sum > 64'hFFFF_FFFF) begin
                  sum = 64'hFFFF_FFFF;
                  sat_mirror = 1'b1;
               end
               grid_mirror[addr] = sum[31:0];
            end
   endtask

   // Sends one request; once accepted, updates the mirror or queues the expected read.
   task automatic send_request(input stim_row_t row);
      cell_read_t exp;
      if (sender_idle > 0 && $urandom_range(99) < sender_idle)
         repeat ($urandom_range(1, 6)) begin
            @(negedge clock);
            req_bus.valid <= 1'b0;
         end
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.kind <= row.kind;
      req_bus.pos_x <= row.x;
      req_bus.pos_y <= row.y;
      req_bus.pos_z <= row.z;
      req_bus.cell_index <= row.index;
      do @(posedge clock); while (!req_bus.ready);
      if (row.kind == KIND_DEPOSIT) begin
         deposit_particle(row.x, row.y, row.z);
      end else begin
         exp.value = grid_mirror[row.index];
         exp.sat = sat_mirror;
         if (row.typed) begin
            exp.value = row.value;
            exp.sat = row.sat;
         end
         pending_reads.push_back(exp);
      end
   endtask

   // Drops valid, waits for every read to return and lets a deposit in flight finish.
   task automatic drain();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_reads.size() != 0) @(negedge clock);
      repeat (250) @(negedge clock);
   endtask

   task automatic write_scheme(input logic [1:0] scheme);
      drain();
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= 2'(REG_SCHEME * 4);
      csr_pwdata <= {30'd0, scheme};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      scheme_mirror = scheme;
   endtask

   // Receiver: random stalls plus an occasional long hold-off.
   always @(negedge clock) begin
      if (long_hold > 0) begin
         rsp_bus.ready <= 1'b0;
         long_hold <= long_hold - 1;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= receiver_idle);
      end
   end

   always @(posedge clock) begin
      cell_read_t exp;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_reads.size() == 0) begin
            $error("cell read result with no request waiting");
            failures++;
         end else begin
            exp = pending_reads.pop_front();
            if (rsp_bus.cell_value !== exp.value) begin
               $error("cell_value expected %h actual %h", exp.value, rsp_bus.cell_value);
               failures++;
            end
            if (rsp_bus.saturated !== exp.sat) begin
               $error("saturated expected %b actual %b", exp.sat, rsp_bus.saturated);
               failures++;
            end
         end
      end
   end

   initial begin
      #12000000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      stim_row_t directed [] = '{
         '{SCHEME_CIC, KIND_READ, 0, 0, 0, 0, 1, 0, 0},
         '{SCHEME_CIC, KIND_DEPOSIT, 0, 0, 0, 0, 0, 0, 0},
         '{SCHEME_CIC, KIND_READ, 0, 0, 0, 0, 1, 32'h0001_0000, 0},
         '{SCHEME_CIC, KIND_READ, 0, 0, 0, 1, 1, 0, 0},
         '{SCHEME_CIC, KIND_DEPOSIT, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 0, 0, 0, 0},
         '{SCHEME_CIC, KIND_READ, 0, 0, 0, 15'h7FFF, 0, 0, 0},
         '{SCHEME_CIC, KIND_READ, 0, 0, 0, 0, 0, 0, 0},
         '{SCHEME_NGP, KIND_DEPOSIT, 24'hFFFFFF, 0, 0, 0, 0, 0, 0},
         '{SCHEME_NGP, KIND_READ, 0, 0, 0, 31, 0, 0, 0},
         '{SCHEME_NGP, KIND_DEPOSIT, 24'h800000, 24'h800000, 24'h800000, 0, 0, 0, 0},
         '{SCHEME_NGP, KIND_READ, 0, 0, 0, 16912, 1, 32'h0001_0000, 0},
         '{SCHEME_TSC, KIND_DEPOSIT, 0, 0, 0, 0, 0, 0, 0},
         '{SCHEME_TSC, KIND_READ, 0, 0, 0, 0, 0, 0, 0},
         '{SCHEME_TSC, KIND_DEPOSIT, 24'h07FFFF, 24'h07FFFF, 24'h080000, 0, 0, 0, 0},
         '{SCHEME_TSC, KIND_READ, 0, 0, 0, 33, 0, 0, 0},
         '{SCHEME_TSC, KIND_DEPOSIT, 24'h080000, 24'hFFFFFF, 24'h000001, 0, 0, 0, 0},
         '{SCHEME_TSC, KIND_READ, 0, 0, 0, 15'h7FFF, 0, 0, 0},
         '{SCHEME_UNUSED, KIND_DEPOSIT, 0, 0, 0, 0, 0, 0, 0},
         '{SCHEME_UNUSED, KIND_READ, 0, 0, 0, 0, 0, 0, 0},
         '{SCHEME_TSC, KIND_READ, 0, 0, 0, 1057, 0, 0, 0}
      };
      stim_row_t row;
      int last_cell;
      logic [1:0] scheme;
      for (int k = 0; k < CELL_COUNT; k++) grid_mirror[k] = '0;
      sat_mirror = 1'b0;
      scheme_mirror = SCHEME_CIC;
      last_cell = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[k]) begin
         if (directed[k].scheme != scheme_mirror) write_scheme(directed[k].scheme);
         send_request(directed[k]);
      end

      for (int phase = 0; phase < 3; phase++) begin
         sender_idle = (phase == 0) ? 21 : (phase == 1) ? 69 : 0;
         receiver_idle = (phase == 0) ? 69 : (phase == 1) ? 21 : 0;
         for (int seg = 0; seg < 8; seg++) begin
            scheme = (seg == 0) ? SCHEME_NGP : (seg == 1) ? SCHEME_TSC
                   : 2'($urandom_range(0, 3));
            write_scheme(scheme);
            if (phase == 0 && seg == 3) long_hold = 3000;
            for (int n = 0; n < 85; n++) begin
               row.scheme = scheme;
               row.typed = 0;
               row.value = '0;
               row.sat = 1'b0;
               row.kind = ($urandom_range(99) < 35) ? KIND_READ : KIND_DEPOSIT;
               row.x = 24'($urandom);
               row.y = 24'($urandom);
               row.z = 24'($urandom);
               // Most reads hit the neighborhood of the last deposit.
               if ($urandom_range(99) < 70)
                  row.index = 15'(last_cell + $urandom_range(0, 66));
               else
                  row.index = 15'($urandom);
               if (row.kind == KIND_DEPOSIT)
                  last_cell = int'(row.x[23:19]) + GRID_SIZE * (int'(row.y[23:19])
                              + GRID_SIZE * int'(row.z[23:19])) - 33;
               send_request(row);
            end
         end
         drain();
      end

      // Pile unit masses onto one cell and read it back.
      write_scheme(SCHEME_NGP);
      row = '{SCHEME_NGP, KIND_DEPOSIT, 24'h123456, 24'hABCDEF, 24'h777777, 0, 0, 0, 0};
      for (int n = 0; n < 40; n++) send_request(row);
      row.kind = KIND_READ;
      row.index = 15'(int'(row.x[23:19]) + GRID_SIZE * (int'(row.y[23:19])
                      + GRID_SIZE * int'(row.z[23:19])));
      send_request(row);
      row.index = 0;
      send_request(row);

      drain();
      failures += pending_reads.size();
      if (failures == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
